[rtl/sda3_pkg.sv]
// Package for the streaming 3-D statistical dominance filter.
// Holds shared widths, register indexes and the scan control struct.
// No dependencies.
package sda3_pkg;

  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRAMES    = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS_SQ = 3'd4;

  localparam int unsigned COUNT_BITS = 10;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = 10'd1023;

  // One request from the scan sequencer to the neighbor accumulator.
  typedef struct packed {
    logic start;   // first read of a new voxel: the center
    logic valid;   // a read address was issued this cycle
    logic use_it;  // neighbor lies in the volume and inside the sphere
    logic done;    // final read of this voxel
  } scan_ctl_t;

endpackage

[rtl/sda3_ring.sv]
// Voxel ring memory: one write port, one registered read port.
// Depends on nothing; widths come from parameters.
module sda3_ring #(
  parameter int unsigned DATA_BITS = 8,
  parameter int unsigned ADDR_BITS = 20,
  parameter int unsigned DEPTH     = 589824
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [ADDR_BITS-1:0] wr_addr,
  input  logic [DATA_BITS-1:0] wr_data,
  input  logic [ADDR_BITS-1:0] rd_addr,
  output logic [DATA_BITS-1:0] rd_data
);

  logic [DATA_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/sda3_accum.sv]
// Neighbor accumulator: compares ring read data against center + threshold.
// Depends on sda3_pkg for the scan control struct and count width.
module sda3_accum #(
  parameter int unsigned VOXEL_BITS = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sda3_pkg::scan_ctl_t             ctl,
  input  logic [VOXEL_BITS-1:0]           rd_data,
  input  logic signed [8:0]               threshold,
  output logic                            res_valid,
  output logic [sda3_pkg::COUNT_BITS-1:0] res_count
);

  sda3_pkg::scan_ctl_t ctl_r;
  logic signed [VOXEL_BITS+1:0] centre_r;
  logic [sda3_pkg::COUNT_BITS-1:0] cnt_r;
  logic signed [VOXEL_BITS+1:0] centre_now;
  logic signed [VOXEL_BITS+1:0] val_ext;
  logic [sda3_pkg::COUNT_BITS-1:0] cnt_base;
  logic hit;
  logic [sda3_pkg::COUNT_BITS-1:0] cnt_nxt;

  // data arriving now belongs to the request of the previous cycle
  always_comb begin
    val_ext    = $signed({2'b00, rd_data});
    centre_now = val_ext + (VOXEL_BITS+2)'(threshold);
    cnt_base   = ctl_r.start ? '0 : cnt_r;
    hit        = ctl_r.use_it &&
                 (val_ext >= (ctl_r.start ? centre_now : centre_r));
    cnt_nxt    = (hit && cnt_base != sda3_pkg::COUNT_MAX) ?
                 cnt_base + 1'b1 : cnt_base;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r     <= '0;
      res_valid <= 1'b0;
    end else begin
      ctl_r     <= ctl;
      res_valid <= ctl_r.valid && ctl_r.done;
    end
    if (ctl_r.valid) begin
      cnt_r <= cnt_nxt;
      if (ctl_r.start) begin
        centre_r <= centre_now;
      end
    end
    res_count <= cnt_nxt;
  end

`ifndef NO_ASSERTIONS
  a_start_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> ctl.valid) else $error("start without valid");
  a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.done |-> ctl.valid) else $error("done without valid");
  a_res_follow: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> $past(ctl_r.done)) else $error("result without done");
`endif

endmodule

[rtl/statistical_dominance_3d.sv]
// Streaming 3-D statistical dominance filter, top level; uses sda3_pkg, sda3_ring, sda3_accum.
// Release: a result is due once MAX_RADIUS*(W*H+W+1) later voxels have arrived, or once the
//   last voxel of the volume has arrived; a scan then reads the centre and every cube offset in
//   turn through the one ring read port, and the accumulated count is registered onto out_tdata.
// Input: a releasing word holds input until its result is taken; other words do not hold it.
// Reset: synchronous active low; positions clear, ring not cleared, input held while settling.
module statistical_dominance_3d #(
  parameter int unsigned MAX_RADIUS = 4,
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HEIGHT = 256,
  parameter int unsigned VOXEL_BITS = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VOXEL_BITS+7)/8)*8-1:0]       in_tdata,  // [VOXEL_BITS-1:0] voxel_value
  input  logic                                  in_tuser,  // command
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [15:0]                           out_tdata, // [9:0] dominance_count
  output logic                                  out_tlast, // last_voxel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sda3_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [15:0]                           cfg_data
);

  localparam int unsigned SPAN   = 2*MAX_RADIUS + 1;
  localparam int unsigned DEPTH  = SPAN*MAX_WIDTH*MAX_HEIGHT;
  localparam int unsigned ABITS  = $clog2(DEPTH);
  localparam int unsigned WBITS  = $clog2(MAX_WIDTH+1);
  localparam int unsigned HBITS  = $clog2(MAX_HEIGHT+1);
  localparam int unsigned PBITS  = WBITS + HBITS + 16;
  localparam int unsigned OBITS  = $clog2(SPAN);
  localparam int unsigned RSQBITS = 6;
  localparam int unsigned DBITS  = $clog2(3*MAX_RADIUS*MAX_RADIUS+1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // configuration
  logic [8:0]  vol_width_r, vol_height_r;
  logic [15:0] vol_frames_r;
  logic signed [8:0] thr_r;
  logic [5:0]  rsq_r;
  logic [WBITS-1:0] w_eff;
  logic [HBITS-1:0] h_eff;
  logic [15:0] f_eff;
  logic [PBITS-1:0] total, lag;

  always_comb begin
    w_eff = (vol_width_r == 9'd0) ? WBITS'(1) :
            (32'(vol_width_r) > MAX_WIDTH) ? WBITS'(MAX_WIDTH) : WBITS'(vol_width_r);
    h_eff = (vol_height_r == 9'd0) ? HBITS'(1) :
            (32'(vol_height_r) > MAX_HEIGHT) ? HBITS'(MAX_HEIGHT) : HBITS'(vol_height_r);
    f_eff = (vol_frames_r == 16'd0) ? 16'd1 : vol_frames_r;
  end

  // products settle into registers after a size config write; input is held meanwhile
  logic [WBITS+HBITS-1:0] wh_r;
  always_ff @(posedge clk) begin
    wh_r  <= w_eff * h_eff;
    total <= PBITS'(wh_r) * PBITS'(f_eff);
    lag   <= PBITS'(MAX_RADIUS) * (PBITS'(wh_r) + PBITS'(w_eff) + PBITS'(1));
  end

  // positions and ring write address tracking
  logic [PBITS-1:0] in_pos_r, out_pos_r;
  logic [ABITS-1:0] wr_addr_r;
  logic [1:0] state_r;
  logic [1:0] settle_r;
  logic signed [WBITS+1:0] ox_r;
  logic signed [HBITS+1:0] oy_r;
  logic signed [17:0] oz_r;
  logic [ABITS-1:0] ob_r; // ring address of the voxel being scanned

  logic cfg_fire, cfg_dim;
  assign cfg_ready = (state_r == ST_IDLE);
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_dim   = (cfg_index == sda3_pkg::REG_WIDTH) || (cfg_index == sda3_pkg::REG_HEIGHT) ||
                     (cfg_index == sda3_pkg::REG_FRAMES);

  logic in_fire, is_data, due;
  logic [PBITS-1:0] in_pos_upd;
  assign is_data   = !in_tuser;
  assign in_tready = (state_r == ST_IDLE) && !cfg_valid && (settle_r == 2'd0);
  assign in_fire   = in_tvalid && in_tready;
  assign in_pos_upd = (in_fire && is_data && in_pos_r < total) ? in_pos_r + 1'b1 : in_pos_r;
  assign due = (out_pos_r < in_pos_upd) &&
               (in_pos_upd == total || (in_pos_upd - 1'b1 - out_pos_r) >= lag);

  // scan offsets
  logic [OBITS-1:0] si_r, sj_r, sk_r;
  logic first_r;
  logic signed [OBITS+1:0] di, dj, dk;
  logic [DBITS-1:0] dsq;
  logic signed [WBITS+3:0] nx;
  logic signed [HBITS+3:0] ny;
  logic signed [18:0] nz;
  logic in_vol;
  logic signed [ABITS+2:0] off_lin;
  logic signed [ABITS+2:0] raddr_s;
  logic [ABITS-1:0] rd_addr, rd_addr_w;
  logic last_off;
  sda3_pkg::scan_ctl_t ctl;
  logic [WBITS+HBITS-1:0] wh_plus;

  always_comb begin
    di  = $signed({2'b00, si_r}) - (OBITS+2)'(MAX_RADIUS);
    dj  = $signed({2'b00, sj_r}) - (OBITS+2)'(MAX_RADIUS);
    dk  = $signed({2'b00, sk_r}) - (OBITS+2)'(MAX_RADIUS);
    dsq = DBITS'(di*di) + DBITS'(dj*dj) + DBITS'(dk*dk);
    nx  = (WBITS+4)'(ox_r) + (WBITS+4)'(di);
    ny  = (HBITS+4)'(oy_r) + (HBITS+4)'(dj);
    nz  = 19'(oz_r) + 19'(dk);
    in_vol = (nx >= 0) && (nx < $signed({4'b0, w_eff})) &&
             (ny >= 0) && (ny < $signed({4'b0, h_eff})) &&
             (nz >= 0) && (nz < $signed({3'b0, f_eff})) &&
             (32'(dsq) <= 32'(rsq_r));
    wh_plus = wh_r;
    // linear ring offset: dk*WH + dj*W + di, one small multiply each for the dk and dj terms
    off_lin = (ABITS+3)'(dk) * $signed({3'b0, ABITS'(wh_plus)}) +
              (ABITS+3)'(dj) * $signed({3'b0, ABITS'(w_eff)}) + (ABITS+3)'(di);
    raddr_s = $signed({3'b0, ob_r}) + off_lin;
    if (raddr_s < 0) begin
      raddr_s = raddr_s + (ABITS+3)'(DEPTH);
    end else if (raddr_s >= (ABITS+3)'(DEPTH)) begin
      raddr_s = raddr_s - (ABITS+3)'(DEPTH);
    end
    rd_addr_w = first_r ? ob_r : ABITS'(raddr_s);
    last_off  = (si_r == OBITS'(SPAN-1)) && (sj_r == OBITS'(SPAN-1)) &&
                (sk_r == OBITS'(SPAN-1));
    ctl.valid  = (state_r == ST_SCAN);
    ctl.start  = (state_r == ST_SCAN) && first_r;
    ctl.use_it = (state_r == ST_SCAN) && (first_r ? 1'b0 : in_vol);
    ctl.done   = (state_r == ST_SCAN) && !first_r && last_off;
  end
  assign rd_addr = rd_addr_w;

  logic res_valid;
  logic [sda3_pkg::COUNT_BITS-1:0] res_count;
  logic last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_width_r <= 9'd256; vol_height_r <= 9'd256; vol_frames_r <= 16'd1;
      thr_r <= '0; rsq_r <= 6'd6;
      in_pos_r <= '0; out_pos_r <= '0; wr_addr_r <= '0;
      state_r <= ST_IDLE; out_tvalid <= 1'b0; settle_r <= 2'd2;
      ox_r <= '0; oy_r <= '0; oz_r <= '0; ob_r <= '0;
      si_r <= '0; sj_r <= '0; sk_r <= '0; first_r <= 1'b0;
    end else begin
      // hold input until the size products have settled
      if (cfg_fire && cfg_dim) begin
        settle_r <= 2'd2;
      end else if (settle_r != 2'd0) begin
        settle_r <= settle_r - 1'b1;
      end
      if (cfg_fire) begin
        case (cfg_index)
          sda3_pkg::REG_WIDTH:     vol_width_r  <= cfg_data[8:0];
          sda3_pkg::REG_HEIGHT:    vol_height_r <= cfg_data[8:0];
          sda3_pkg::REG_FRAMES:    vol_frames_r <= cfg_data;
          sda3_pkg::REG_THRESHOLD: thr_r        <= $signed(cfg_data[8:0]);
          sda3_pkg::REG_RADIUS_SQ: rsq_r        <= cfg_data[RSQBITS-1:0];
          default: ;
        endcase
        if (cfg_dim) begin
          in_pos_r <= '0; out_pos_r <= '0; wr_addr_r <= '0;
          ox_r <= '0; oy_r <= '0; oz_r <= '0; ob_r <= '0;
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            in_pos_r <= in_pos_upd;
            if (in_pos_upd != in_pos_r) begin
              wr_addr_r <= (wr_addr_r == ABITS'(DEPTH-1)) ? '0 : wr_addr_r + 1'b1;
            end
            if (due) begin
              state_r <= ST_SCAN; first_r <= 1'b1;
              si_r <= '0; sj_r <= '0; sk_r <= '0;
              last_r <= (out_pos_r + 1'b1 == total);
            end
          end
        end
        ST_SCAN: begin
          first_r <= 1'b0;
          if (!first_r) begin
            if (last_off) begin
              state_r <= ST_WAIT;
            end else if (si_r != OBITS'(SPAN-1)) begin
              si_r <= si_r + 1'b1;
            end else begin
              si_r <= '0;
              if (sj_r != OBITS'(SPAN-1)) begin
                sj_r <= sj_r + 1'b1;
              end else begin
                sj_r <= '0; sk_r <= sk_r + 1'b1;
              end
            end
          end
        end
        ST_WAIT: begin
          if (res_valid) begin
            out_tvalid <= 1'b1; state_r <= ST_OUT;
            out_tdata  <= 16'(res_count);
            out_tlast  <= last_r;
          end
        end
        ST_OUT: begin
          if (out_tready) begin
            out_tvalid <= 1'b0; state_r <= ST_IDLE;
            if (last_r) begin
              out_pos_r <= '0; in_pos_r <= '0; wr_addr_r <= '0;
              ox_r <= '0; oy_r <= '0; oz_r <= '0; ob_r <= '0;
            end else begin
              out_pos_r <= out_pos_r + 1'b1;
              ob_r <= (ob_r == ABITS'(DEPTH-1)) ? '0 : ob_r + 1'b1;
              // advance raster coordinates of the next result
              if ((WBITS+2)'(ox_r) + 1 == (WBITS+2)'(w_eff)) begin
                ox_r <= '0;
                if ((HBITS+2)'(oy_r) + 1 == (HBITS+2)'(h_eff)) begin
                  oy_r <= '0; oz_r <= oz_r + 1'b1;
                end else begin
                  oy_r <= oy_r + 1'b1;
                end
              end else begin
                ox_r <= ox_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  logic [VOXEL_BITS-1:0] rd_data;

  sda3_ring #(
    .DATA_BITS(VOXEL_BITS), .ADDR_BITS(ABITS), .DEPTH(DEPTH)
  ) u_ring (
    .clk(clk),
    .wr_en(in_fire && (in_pos_upd != in_pos_r)),
    .wr_addr(wr_addr_r),
    .wr_data(in_tdata[VOXEL_BITS-1:0]),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  sda3_accum #(.VOXEL_BITS(VOXEL_BITS)) u_accum (
    .clk(clk), .rst_n(rst_n), .ctl(ctl), .rd_data(rd_data),
    .threshold(thr_r), .res_valid(res_valid), .res_count(res_count)
  );

`ifndef NO_ASSERTIONS
  a_out_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_pos_r <= in_pos_r) else $error("output ahead of input");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !in_tready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid) else $error("result dropped");
`endif

endmodule
